>>> hw/rtl/spcf_pkg.sv
// ----------------------------------------------------------------------------
// spcf_pkg: shared definitions for the spectrum peak candidate finder
// Sizes, register indexes, binomial weight table and controller/datapath
// command and status types.
// ----------------------------------------------------------------------------
package spcf_pkg;

  localparam int unsigned MAX_CHANNELS_DEF   = 16384;
  localparam int unsigned COUNT_BITS_DEF     = 24;
  localparam int unsigned MAX_HALF_WIDTH_DEF = 8;

  localparam int unsigned EDGE_SKIP = 10;
  localparam int unsigned LAG       = EDGE_SKIP - 2;
  localparam int unsigned WIN_DEPTH = 2 * LAG + 1;
  localparam int unsigned WIN_IDX_W = $clog2(WIN_DEPTH);

  localparam int unsigned IDX_W      = 14;
  localparam int unsigned TOTAL_W    = 15;
  localparam int unsigned HW_W       = 4;
  localparam int unsigned PK_W       = 16;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  localparam int unsigned MUL_W  = 32;
  localparam int unsigned PROD_W = 2 * MUL_W;
  localparam int unsigned WIDE_W = 2 * MUL_W;
  localparam int unsigned WGT_W  = 14;

  localparam logic [CFG_IDX_W-1:0] REG_HALF_WIDTH = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_PK_CUT     = CFG_IDX_W'(1);

  localparam logic [HW_W-1:0] HALF_WIDTH_RESET = HW_W'(2);
  localparam logic [PK_W-1:0] PK_CUT_RESET     = PK_W'(768);

  // Row n holds C(2n, j) for j = 0 .. 2n.
  localparam logic [WGT_W-1:0] BINOM [9][17] = '{
    '{14'd1, 14'd0, 14'd0, 14'd0, 14'd0, 14'd0, 14'd0, 14'd0, 14'd0,
      14'd0, 14'd0, 14'd0, 14'd0, 14'd0, 14'd0, 14'd0, 14'd0},
    '{14'd1, 14'd2, 14'd1, 14'd0, 14'd0, 14'd0, 14'd0, 14'd0, 14'd0,
      14'd0, 14'd0, 14'd0, 14'd0, 14'd0, 14'd0, 14'd0, 14'd0},
    '{14'd1, 14'd4, 14'd6, 14'd4, 14'd1, 14'd0, 14'd0, 14'd0, 14'd0,
      14'd0, 14'd0, 14'd0, 14'd0, 14'd0, 14'd0, 14'd0, 14'd0},
    '{14'd1, 14'd6, 14'd15, 14'd20, 14'd15, 14'd6, 14'd1, 14'd0, 14'd0,
      14'd0, 14'd0, 14'd0, 14'd0, 14'd0, 14'd0, 14'd0, 14'd0},
    '{14'd1, 14'd8, 14'd28, 14'd56, 14'd70, 14'd56, 14'd28, 14'd8, 14'd1,
      14'd0, 14'd0, 14'd0, 14'd0, 14'd0, 14'd0, 14'd0, 14'd0},
    '{14'd1, 14'd10, 14'd45, 14'd120, 14'd210, 14'd252, 14'd210, 14'd120,
      14'd45, 14'd10, 14'd1, 14'd0, 14'd0, 14'd0, 14'd0, 14'd0, 14'd0},
    '{14'd1, 14'd12, 14'd66, 14'd220, 14'd495, 14'd792, 14'd924, 14'd792,
      14'd495, 14'd220, 14'd66, 14'd12, 14'd1, 14'd0, 14'd0, 14'd0, 14'd0},
    '{14'd1, 14'd14, 14'd91, 14'd364, 14'd1001, 14'd2002, 14'd3003, 14'd3432,
      14'd3003, 14'd2002, 14'd1001, 14'd364, 14'd91, 14'd14, 14'd1, 14'd0, 14'd0},
    '{14'd1, 14'd16, 14'd120, 14'd560, 14'd1820, 14'd4368, 14'd8008, 14'd11440,
      14'd12870, 14'd11440, 14'd8008, 14'd4368, 14'd1820, 14'd560, 14'd120,
      14'd16, 14'd1}
  };

  typedef enum logic [2:0] {
    MUL_TAP,
    MUL_PP,
    MUL_M00,
    MUL_M01,
    MUL_M10,
    MUL_M11,
    MUL_R0,
    MUL_R1
  } mul_sel_e;

  typedef struct packed {
    logic                 win_shift;
    logic                 mul_en;
    mul_sel_e             mul_sel;
    logic [WIN_IDX_W-1:0] tap;
    logic                 update;
    logic                 load_cand;
    logic                 load_sum;
  } dp_cmd_t;

  typedef struct packed {
    logic [HW_W-1:0] n;
    logic            below_max;
    logic            edge_ok;
    logic            shape_ok;
    logic            cut_pass;
    logic            out_free;
  } dp_status_t;

endpackage

>>> hw/rtl/spcf_if.sv
// ----------------------------------------------------------------------------
// spcf_if: stream channels of the spectrum peak candidate finder
// Input channel carries channel counts, output channel carries results.
// ----------------------------------------------------------------------------
interface spcf_in_if #(
  parameter int unsigned COUNT_BITS = spcf_pkg::COUNT_BITS_DEF
);
  logic                  valid;
  logic                  ready;
  logic [COUNT_BITS-1:0] count_value;
  logic                  last_channel;

  modport source (output valid, output count_value, output last_channel, input ready);
  modport sink   (input valid, input count_value, input last_channel, output ready);
endinterface

interface spcf_out_if;
  logic                         valid;
  logic                         ready;
  logic [spcf_pkg::IDX_W-1:0]   channel_index;
  logic                         is_summary;
  logic [spcf_pkg::TOTAL_W-1:0] candidate_total;

  modport source (output valid, output channel_index, output is_summary,
                  output candidate_total, input ready);
  modport sink   (input valid, input channel_index, input is_summary,
                  input candidate_total, output ready);
endinterface

>>> hw/rtl/spcf_ctrl.sv
// ----------------------------------------------------------------------------
// spcf_ctrl: sequencer of the spectrum peak candidate finder
// Steps the tap multiply-accumulate, the cut products and result loads.
// ----------------------------------------------------------------------------
module spcf_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_last_i,
  output logic                 in_ready_o,
  input  spcf_pkg::dp_status_t status_i,
  output spcf_pkg::dp_cmd_t    cmd_o
);
  import spcf_pkg::*;

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_MAC     = 4'd1;
  localparam logic [3:0] S_DRAIN   = 4'd2;
  localparam logic [3:0] S_UPDATE  = 4'd3;
  localparam logic [3:0] S_TEST    = 4'd4;
  localparam logic [3:0] S_CUT     = 4'd5;
  localparam logic [3:0] S_CDRAIN  = 4'd6;
  localparam logic [3:0] S_COMPARE = 4'd7;
  localparam logic [3:0] S_EMIT    = 4'd8;
  localparam logic [3:0] S_SUMM    = 4'd9;

  localparam logic [WIN_IDX_W-1:0] CUT_LAST = WIN_IDX_W'(6);

  logic [3:0]           state_q, state_d;
  logic [WIN_IDX_W-1:0] step_q, step_d;
  logic                 last_q, last_d;
  logic [WIN_IDX_W-1:0] tap_end;

  assign tap_end = WIN_IDX_W'({status_i.n, 1'b0});

  always_comb begin
    state_d    = state_q;
    step_d     = step_q;
    last_d     = last_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    cmd_o.tap  = step_q;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          last_d = in_last_i;
          step_d = '0;
          if (status_i.below_max) begin
            cmd_o.win_shift = 1'b1;
            state_d         = S_MAC;
          end else if (in_last_i) begin
            state_d = S_SUMM;
          end
        end
      end
      S_MAC: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_TAP;
        if (step_q == tap_end) begin
          state_d = S_DRAIN;
        end else begin
          step_d = step_q + 1'b1;
        end
      end
      S_DRAIN: state_d = S_UPDATE;
      S_UPDATE: begin
        cmd_o.update = 1'b1;
        state_d      = S_TEST;
      end
      S_TEST: begin
        step_d = '0;
        if (status_i.edge_ok && status_i.shape_ok) begin
          state_d = S_CUT;
        end else begin
          state_d = last_q ? S_SUMM : S_IDLE;
        end
      end
      S_CUT: begin
        cmd_o.mul_en = 1'b1;
        unique case (step_q[2:0])
          3'd0:    cmd_o.mul_sel = MUL_PP;
          3'd1:    cmd_o.mul_sel = MUL_M00;
          3'd2:    cmd_o.mul_sel = MUL_M01;
          3'd3:    cmd_o.mul_sel = MUL_M10;
          3'd4:    cmd_o.mul_sel = MUL_M11;
          3'd5:    cmd_o.mul_sel = MUL_R0;
          default: cmd_o.mul_sel = MUL_R1;
        endcase
        if (step_q == CUT_LAST) begin
          state_d = S_CDRAIN;
        end else begin
          step_d = step_q + 1'b1;
        end
      end
      S_CDRAIN: state_d = S_COMPARE;
      S_COMPARE: begin
        if (status_i.cut_pass) begin
          state_d = S_EMIT;
        end else begin
          state_d = last_q ? S_SUMM : S_IDLE;
        end
      end
      S_EMIT: begin
        if (status_i.out_free) begin
          cmd_o.load_cand = 1'b1;
          state_d         = last_q ? S_SUMM : S_IDLE;
        end
      end
      S_SUMM: begin
        if (status_i.out_free) begin
          cmd_o.load_sum = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      step_q  <= '0;
      last_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      last_q  <= last_d;
    end
  end

  a_single_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_o.load_cand && cmd_o.load_sum))
    else $error("candidate and summary loaded together");

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.load_cand || cmd_o.load_sum) |-> status_i.out_free)
    else $error("result loaded over a pending one");

  a_tap_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MAC) |-> (step_q <= tap_end))
    else $error("tap step beyond window");

endmodule

>>> hw/rtl/spcf_datapath.sv
// ----------------------------------------------------------------------------
// spcf_datapath: storage and arithmetic of the spectrum peak candidate finder
// Count window, shared 32x32 multiplier, sums, differences, cut test, output.
// ----------------------------------------------------------------------------
module spcf_datapath #(
  parameter int unsigned MAX_CHANNELS   = spcf_pkg::MAX_CHANNELS_DEF,
  parameter int unsigned COUNT_BITS     = spcf_pkg::COUNT_BITS_DEF,
  parameter int unsigned MAX_HALF_WIDTH = spcf_pkg::MAX_HALF_WIDTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [spcf_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [spcf_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic [COUNT_BITS-1:0]         count_i,
  input  spcf_pkg::dp_cmd_t             cmd_i,
  output spcf_pkg::dp_status_t          status_o,
  input  logic                          out_ready_i,
  output logic                          out_valid_o,
  output logic [spcf_pkg::IDX_W-1:0]    out_index_o,
  output logic                          out_summary_o,
  output logic [spcf_pkg::TOTAL_W-1:0]  out_total_o
);
  import spcf_pkg::*;

  localparam int unsigned CNT_W = $clog2(MAX_CHANNELS + 1);
  localparam int unsigned S_W   = COUNT_BITS + 16;
  localparam int unsigned D_W   = S_W + 2;
  localparam int unsigned V_W   = S_W + 3;
  localparam int unsigned L_W   = 2 * WIDE_W;
  localparam int unsigned R_W   = MUL_W + WIDE_W;
  localparam int unsigned CMP_W = L_W + 16;

  logic [HW_W-1:0] hw_q;
  logic [PK_W-1:0] pk_q;
  logic [HW_W-1:0] n_sat;
  logic [HW_W-1:0] n_q;

  logic [COUNT_BITS-1:0] win_q [WIN_DEPTH];
  logic [S_W-1:0]        s_q   [3];
  logic signed [D_W-1:0] d_q   [3];
  logic [V_W-1:0]        v_q   [2];
  logic [CNT_W-1:0]      cnt_q, cand_q, k_q;

  logic [S_W-1:0]    sum_q;
  logic [MUL_W-1:0]  p2_q;
  logic [L_W-1:0]    l_q;
  logic [R_W-1:0]    r_q;
  logic [PROD_W-1:0] prod_q;
  mul_sel_e          tag_q;
  logic              tag_vld_q;

  logic [MUL_W-1:0]      mul_a, mul_b;
  logic [WIN_IDX_W-1:0]  tap_idx;
  logic signed [D_W-1:0] neg_d, d_new;
  logic [WIDE_W-1:0]     mag, var_w;
  logic [V_W-1:0]        v_new;
  logic [CMP_W-1:0]      lhs, rhs;

  logic                  out_valid_q, out_summary_q;
  logic [IDX_W-1:0]      out_index_q;
  logic [TOTAL_W-1:0]    out_total_q;

  assign n_sat = (hw_q > HW_W'(MAX_HALF_WIDTH)) ? HW_W'(MAX_HALF_WIDTH) : hw_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hw_q <= HALF_WIDTH_RESET;
      pk_q <= PK_CUT_RESET;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == REG_HALF_WIDTH) hw_q <= cfg_data_i[HW_W-1:0];
      if (cfg_idx_i == REG_PK_CUT)     pk_q <= cfg_data_i[PK_W-1:0];
    end
  end

  // Operand selection for the shared multiplier.
  assign tap_idx = WIN_IDX_W'(LAG) + WIN_IDX_W'(n_q) - cmd_i.tap;
  assign neg_d   = -d_q[1];
  assign mag     = WIDE_W'($unsigned(neg_d));
  assign var_w   = WIDE_W'(v_q[0]);

  always_comb begin
    unique case (cmd_i.mul_sel)
      MUL_TAP: begin
        mul_a = MUL_W'(win_q[tap_idx]);
        mul_b = MUL_W'(BINOM[n_q][cmd_i.tap]);
      end
      MUL_PP: begin
        mul_a = MUL_W'(pk_q);
        mul_b = MUL_W'(pk_q);
      end
      MUL_M00: begin
        mul_a = mag[MUL_W-1:0];
        mul_b = mag[MUL_W-1:0];
      end
      MUL_M01: begin
        mul_a = mag[MUL_W-1:0];
        mul_b = mag[WIDE_W-1:MUL_W];
      end
      MUL_M10: begin
        mul_a = mag[WIDE_W-1:MUL_W];
        mul_b = mag[MUL_W-1:0];
      end
      MUL_M11: begin
        mul_a = mag[WIDE_W-1:MUL_W];
        mul_b = mag[WIDE_W-1:MUL_W];
      end
      MUL_R0: begin
        mul_a = p2_q;
        mul_b = var_w[MUL_W-1:0];
      end
      default: begin
        mul_a = p2_q;
        mul_b = var_w[WIDE_W-1:MUL_W];
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_vld_q <= 1'b0;
    end else begin
      tag_vld_q <= cmd_i.mul_en;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
    tag_q  <= cmd_i.mul_sel;
  end

  // Accumulate or load the registered product into its destination.
  always_ff @(posedge clk_i) begin
    if (cmd_i.win_shift) begin
      sum_q <= '0;
      p2_q  <= '0;
      l_q   <= '0;
      r_q   <= '0;
    end else if (tag_vld_q) begin
      unique case (tag_q)
        MUL_TAP: sum_q <= sum_q + S_W'(prod_q);
        MUL_PP:  p2_q  <= prod_q[MUL_W-1:0];
        MUL_M00: l_q   <= l_q + L_W'(prod_q);
        MUL_M01: l_q   <= l_q + (L_W'(prod_q) << MUL_W);
        MUL_M10: l_q   <= l_q + (L_W'(prod_q) << MUL_W);
        MUL_M11: l_q   <= l_q + (L_W'(prod_q) << WIDE_W);
        MUL_R0:  r_q   <= r_q + R_W'(prod_q);
        default: r_q   <= r_q + (R_W'(prod_q) << MUL_W);
      endcase
    end
  end

  assign d_new = $signed({2'b00, s_q[1]}) + $signed({2'b00, sum_q})
               - $signed({1'b0, s_q[2], 1'b0});
  assign v_new = V_W'(s_q[1]) + V_W'(sum_q) + {1'b0, s_q[2], 2'b00};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < WIN_DEPTH; i++) win_q[i] <= '0;
      for (int i = 0; i < 3; i++) begin
        s_q[i] <= '0;
        d_q[i] <= '0;
      end
      v_q[0] <= '0;
      v_q[1] <= '0;
      cnt_q  <= '0;
      cand_q <= '0;
      k_q    <= '0;
      n_q    <= '0;
    end else if (cmd_i.load_sum) begin
      for (int i = 0; i < WIN_DEPTH; i++) win_q[i] <= '0;
      for (int i = 0; i < 3; i++) begin
        s_q[i] <= '0;
        d_q[i] <= '0;
      end
      v_q[0] <= '0;
      v_q[1] <= '0;
      cnt_q  <= '0;
      cand_q <= '0;
    end else begin
      if (cmd_i.win_shift) begin
        win_q[0] <= count_i;
        for (int i = 1; i < WIN_DEPTH; i++) win_q[i] <= win_q[i-1];
        k_q <= cnt_q;
        n_q <= n_sat;
      end
      if (cmd_i.update) begin
        s_q[0] <= s_q[1];
        s_q[1] <= s_q[2];
        s_q[2] <= sum_q;
        d_q[0] <= d_q[1];
        d_q[1] <= d_q[2];
        d_q[2] <= d_new;
        v_q[0] <= v_q[1];
        v_q[1] <= v_new;
        cnt_q  <= cnt_q + 1'b1;
      end
      if (cmd_i.load_cand) cand_q <= cand_q + 1'b1;
    end
  end

  assign lhs = {l_q, 16'h0000};
  assign rhs = CMP_W'(r_q) << {n_q, 1'b0};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_cand || cmd_i.load_sum) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_cand) begin
      out_index_q   <= IDX_W'(k_q - CNT_W'(EDGE_SKIP));
      out_summary_q <= 1'b0;
      out_total_q   <= '0;
    end else if (cmd_i.load_sum) begin
      out_index_q   <= '0;
      out_summary_q <= 1'b1;
      out_total_q   <= TOTAL_W'(cand_q);
    end
  end

  assign status_o.n         = n_q;
  assign status_o.below_max = (cnt_q < CNT_W'(MAX_CHANNELS));
  assign status_o.edge_ok   = (k_q >= CNT_W'(2 * EDGE_SKIP));
  assign status_o.shape_ok  = (d_q[1] < 0) && (d_q[0] > d_q[1]) && (d_q[2] > d_q[1]);
  assign status_o.cut_pass  = (lhs > rhs);
  assign status_o.out_free  = !out_valid_q || out_ready_i;

  assign out_valid_o   = out_valid_q;
  assign out_index_o   = out_index_q;
  assign out_summary_o = out_summary_q;
  assign out_total_o   = out_total_q;

  a_clear_after_summary: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load_sum |=> (cnt_q == '0) && (cand_q == '0))
    else $error("spectrum state not cleared after summary");

endmodule

>>> hw/rtl/spectrum_peak_candidate_finder_top.sv
// ----------------------------------------------------------------------------
// spectrum_peak_candidate_finder_top: second-difference peak candidate search
// Binomially smoothed spectrum, squared sigma cut, strict local minimum test.
// ----------------------------------------------------------------------------
// Sequence: each channel runs its smoothing taps, an update and the edge and
//   shape test; a passing test adds the cut products and compare, and a
//   passing cut loads a candidate into the output register; a closing channel
//   adds the summary transaction.
// Sharing: a new channel is taken only once the last one is done; the single
//   shared 32x32 multiplier runs all smoothing taps and the cut products.
// Reset: asynchronous, active low; clears window, sums, counters, and
//   returns half width to 2 and pk_cut to 768 (3.0 sigma).
// ----------------------------------------------------------------------------
module spectrum_peak_candidate_finder_top #(
  parameter int unsigned MAX_CHANNELS   = spcf_pkg::MAX_CHANNELS_DEF,
  parameter int unsigned COUNT_BITS     = spcf_pkg::COUNT_BITS_DEF,
  parameter int unsigned MAX_HALF_WIDTH = spcf_pkg::MAX_HALF_WIDTH_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [spcf_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [spcf_pkg::CFG_DATA_W-1:0] cfg_data_i,
  spcf_in_if.sink                         in_i,
  spcf_out_if.source                      out_o
);
  import spcf_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;
  logic       in_ready;

  // Controller: walks each transaction through taps, update, test, cut, emit.
  spcf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_last_i  (in_i.last_channel),
    .in_ready_o (in_ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // Datapath: window, shared multiplier, decision logic and output register.
  // The output register lets a new transaction enter while a result waits.
  spcf_datapath #(
    .MAX_CHANNELS   (MAX_CHANNELS),
    .COUNT_BITS     (COUNT_BITS),
    .MAX_HALF_WIDTH (MAX_HALF_WIDTH)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .count_i       (in_i.count_value),
    .cmd_i         (cmd),
    .status_o      (status),
    .out_ready_i   (out_o.ready),
    .out_valid_o   (out_o.valid),
    .out_index_o   (out_o.channel_index),
    .out_summary_o (out_o.is_summary),
    .out_total_o   (out_o.candidate_total)
  );

  assign in_i.ready = in_ready;

endmodule
